// File: rtl/pmsp_pkg.sv
package pmsp_pkg;

   localparam int unsigned TickW   = 24;
   localparam int unsigned PeriodW = 32;
   localparam int unsigned TimeW   = 26;

   localparam logic [TickW-1:0]   TICK_MAX   = '1;
   localparam logic [PeriodW-1:0] PERIOD_MAX = '1;

   // Register indexes on the configuration port.
   localparam logic [2:0] REG_R_TICKS   = 3'd0;
   localparam logic [2:0] REG_FI_TICKS  = 3'd1;
   localparam logic [2:0] REG_R_DRIFT   = 3'd2;
   localparam logic [2:0] REG_MIN_R     = 3'd3;
   localparam logic [2:0] REG_MIN_FI    = 3'd4;

   // Payload that moves from one cell of the chain to the next.
   typedef struct packed {
      logic        vld;
      logic [23:0] ar;
      logic [23:0] af;
      logic        r_neg;
      logic        fi_pos;
      logic [25:0] t;
      logic [49:0] rt_prod;    // ar * r_coef
      logic [43:0] mm;         // af * drift
      logic [47:0] fi_prod;    // af * fi_coef
      logic [67:0] corr_prod;  // mm[21:0] * r_coef, low half of mm * r_coef
      logic [23:0] r_ticks;
      logic        r_dir;
      logic [23:0] fi_ticks;
      logic [26:0] num_r;      // t + r_ticks
      logic [26:0] num_fi;
      logic [24:0] den_r;      // 2 * r_ticks
      logic [24:0] den_fi;
      logic [26:0] rem_r;
      logic [26:0] rem_fi;
      logic [31:0] rp;
      logic [31:0] fp;
      logic [47:0] sc_num;     // other * minimum
      logic [31:0] sc_den;
      logic [47:0] sc_rem;
      logic [47:0] sc_q;
   } cell_data_type;

   typedef struct packed {
      logic [23:0] r_coef;
      logic [23:0] fi_coef;
      logic [19:0] drift;
      logic [15:0] min_r;
      logic [15:0] min_fi;
   } cfg_type;

endpackage

// File: rtl/polar_move_step_planner_unit.sv
// Polar move step planner: one move in, one step plan out, fully pipelined as a chain of
// cells. A new move is accepted every cycle while the chain is not stalled; the pipeline
// is five front-end stages, 26 period-divider cells, two clamp stages each feeding a
// 48-cell ratio-scaling chain, and the output register. The chain stalls as a whole
// only when the output register holds a result that is not taken.
module polar_move_step_planner_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,   // delta_r[23:0], delta_fi[47:24], move_time[73:48]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [119:0] rsp_tdata,  // r_ticks, r_dir, fi_ticks, fi_dir, r_period, fi_period
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int unsigned NDiv = 26;
   localparam int unsigned NSc  = 48;

   pmsp_pkg::cfg_type cfg_ff;
   logic wr;
   logic [2:0] widx;
   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;
   assign widx = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.r_coef <= 24'd25600;
         cfg_ff.fi_coef <= 24'd163840;
         cfg_ff.drift <= 20'd65536;
         cfg_ff.min_r <= 16'd50;
         cfg_ff.min_fi <= 16'd50;
      end else if (wr) begin
         unique case (widx)
            pmsp_pkg::REG_R_TICKS:  cfg_ff.r_coef  <= csr_pwdata[23:0];
            pmsp_pkg::REG_FI_TICKS: cfg_ff.fi_coef <= csr_pwdata[23:0];
            pmsp_pkg::REG_R_DRIFT:  cfg_ff.drift   <= csr_pwdata[19:0];
            pmsp_pkg::REG_MIN_R:    cfg_ff.min_r   <= csr_pwdata[15:0];
            pmsp_pkg::REG_MIN_FI:   cfg_ff.min_fi  <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (widx)
         pmsp_pkg::REG_R_TICKS:  csr_prdata = {8'd0, cfg_ff.r_coef};
         pmsp_pkg::REG_FI_TICKS: csr_prdata = {8'd0, cfg_ff.fi_coef};
         pmsp_pkg::REG_R_DRIFT:  csr_prdata = {12'd0, cfg_ff.drift};
         pmsp_pkg::REG_MIN_R:    csr_prdata = {16'd0, cfg_ff.min_r};
         pmsp_pkg::REG_MIN_FI:   csr_prdata = {16'd0, cfg_ff.min_fi};
         default:                csr_prdata = 32'd0;
      endcase
   end

   logic adv;
   logic out_vld_ff;
   logic [119:0] out_data_ff;
   assign adv = !out_vld_ff || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata = out_data_ff;

   // front end: s0 magnitudes, s1 products, s2 correction product, s3 ticks, s4 dividers setup
   pmsp_pkg::cell_data_type s0_ff, s1_ff, s2_ff, s3_ff, s4_ff;
   pmsp_pkg::cell_data_type s0_in, s1_in, s2_in, s3_in, s4_in;
   logic [23:0] dr, df;
   logic [68:0] corr_full;
   logic [25:0] rt_full, corr26, ft_full, rsum, rdiff_a, rdiff_b, rmag;
   logic add_c, pos_c;

   always_comb begin
      dr = req_tdata[23:0];
      df = req_tdata[47:24];
      s0_in = '0;
      s0_in.vld = req_tvalid;
      s0_in.r_neg = dr[23];
      s0_in.ar = dr[23] ? (24'd0 - dr) : dr;
      s0_in.af = df[23] ? (24'd0 - df) : df;
      s0_in.fi_pos = !df[23] && (df != 24'd0);
      s0_in.t = req_tdata[73:48];
      // note: 0x800000 gives magnitude 2^23, which wraps to itself in 24 bits
   end

   always_comb begin
      s1_in = s0_ff;
      s1_in.rt_prod = {26'd0, s0_ff.ar} * {26'd0, cfg_ff.r_coef};
      s1_in.mm = {20'd0, s0_ff.af} * {24'd0, cfg_ff.drift};
      s1_in.fi_prod = {24'd0, s0_ff.af} * {24'd0, cfg_ff.fi_coef};
   end

   logic [67:0] cp_lo, cp_hi;
   always_comb begin
      s2_in = s1_ff;
      // split 44x24 product into two narrower halves, summed next stage
      cp_lo = {36'd0, s1_ff.mm[21:0], 10'd0} >> 10;
      cp_lo = cp_lo * {44'd0, cfg_ff.r_coef};
      cp_hi = {46'd0, s1_ff.mm[43:22]} * {44'd0, cfg_ff.r_coef};
      s2_in.corr_prod = cp_lo;
      s2_in.sc_num = cp_hi[47:0];
   end

   always_comb begin
      s3_in = s2_ff;
      corr_full = {1'b0, s2_ff.corr_prod} + ({21'd0, s2_ff.sc_num} << 22) + (69'd1 << 43);
      corr26 = corr_full[68:44] > 25'h0FFFFFF ? 26'h1000000 : {1'b0, corr_full[68:44]};
      rt_full = (s2_ff.rt_prod[49:17] + 33'd1) >> 1 > 33'h1FFFFFF ? 26'h1FFFFFF
              : 26'(((s2_ff.rt_prod[49:17] + 33'd1) >> 1));
      ft_full = 26'(((s2_ff.fi_prod[47:27] + 21'd1) >> 1));
      add_c = s2_ff.fi_pos ? !s2_ff.r_neg : s2_ff.r_neg;
      pos_c = rt_full > corr26;
      rsum = rt_full + corr26;
      rdiff_a = rt_full - corr26;
      rdiff_b = corr26 - rt_full;
      rmag = add_c ? rsum : (pos_c ? rdiff_a : rdiff_b);
      s3_in.r_ticks = rmag > 26'(pmsp_pkg::TICK_MAX) ? pmsp_pkg::TICK_MAX : rmag[23:0];
      s3_in.fi_ticks = ft_full > 26'(pmsp_pkg::TICK_MAX) ? pmsp_pkg::TICK_MAX : ft_full[23:0];
      if (add_c) s3_in.r_dir = !s2_ff.fi_pos;
      else s3_in.r_dir = s2_ff.fi_pos ? pos_c : !pos_c;
   end

   always_comb begin
      s4_in = s3_ff;
      s4_in.num_r = {1'b0, s3_ff.t} + {3'd0, s3_ff.r_ticks};
      s4_in.num_fi = {1'b0, s3_ff.t} + {3'd0, s3_ff.fi_ticks};
      s4_in.rem_r = s4_in.num_r;
      s4_in.rem_fi = s4_in.num_fi;
      s4_in.den_r = {s3_ff.r_ticks, 1'b0};
      s4_in.den_fi = {s3_ff.fi_ticks, 1'b0};
      s4_in.rp = '0;
      s4_in.fp = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_ff.vld <= 1'b0; s1_ff.vld <= 1'b0; s2_ff.vld <= 1'b0;
         s3_ff.vld <= 1'b0; s4_ff.vld <= 1'b0;
      end else if (adv) begin
         s0_ff.vld <= s0_in.vld; s1_ff.vld <= s1_in.vld; s2_ff.vld <= s2_in.vld;
         s3_ff.vld <= s3_in.vld; s4_ff.vld <= s4_in.vld;
      end
      if (adv) begin
         s0_ff[$bits(s0_ff)-2:0] <= s0_in[$bits(s0_ff)-2:0];
         s1_ff[$bits(s1_ff)-2:0] <= s1_in[$bits(s1_ff)-2:0];
         s2_ff[$bits(s2_ff)-2:0] <= s2_in[$bits(s2_ff)-2:0];
         s3_ff[$bits(s3_ff)-2:0] <= s3_in[$bits(s3_ff)-2:0];
         s4_ff[$bits(s4_ff)-2:0] <= s4_in[$bits(s4_ff)-2:0];
      end
   end

   // period divider chain
   pmsp_pkg::cell_data_type dchain [NDiv+1];
   assign dchain[0] = s4_ff;
   for (genvar g = 0; g < NDiv; g++) begin : g_div
      pmsp_div_cell #(.BitIdx(NDiv-1-g)) u_cell (
         .clock(clock), .reset(reset), .adv(adv), .d_in(dchain[g]), .d_out(dchain[g+1]));
   end

   // radius clamp setup: ticks zero gives period 0
   pmsp_pkg::cell_data_type c0_ff, c0_in, c1_ff, c1_in, c2_in;
   logic r_clamp, f_clamp;
   always_comb begin
      c0_in = dchain[NDiv];
      if (c0_in.r_ticks == 24'd0) c0_in.rp = '0;
      if (c0_in.fi_ticks == 24'd0) c0_in.fp = '0;
      r_clamp = c0_in.r_ticks != 24'd0 && c0_in.rp < {16'd0, cfg_ff.min_r};
      c0_in.sc_num = {16'd0, c0_in.fp} * {32'd0, r_clamp ? cfg_ff.min_r : 16'd1};
      c0_in.sc_den = r_clamp ? ((c0_in.rp == 32'd0) ? 32'd1 : c0_in.rp) : 32'd1;
      c0_in.sc_rem = c0_in.sc_num;
      c0_in.sc_q = '0;
      if (r_clamp) c0_in.rp = {16'd0, cfg_ff.min_r};
   end

   pmsp_pkg::cell_data_type ach [NSc+1];
   assign ach[0] = c0_ff;
   for (genvar g = 0; g < NSc; g++) begin : g_sa
      pmsp_scale_cell #(.BitIdx(NSc-1-g)) u_cell (
         .clock(clock), .reset(reset), .adv(adv), .d_in(ach[g]), .d_out(ach[g+1]));
   end

   always_comb begin
      c1_in = ach[NSc];
      c1_in.fp = c1_in.sc_q > {16'd0, pmsp_pkg::PERIOD_MAX} ? pmsp_pkg::PERIOD_MAX
               : c1_in.sc_q[31:0];
      f_clamp = c1_in.fi_ticks != 24'd0 && c1_in.fp < {16'd0, cfg_ff.min_fi};
      c1_in.sc_num = {16'd0, c1_in.rp} * {32'd0, f_clamp ? cfg_ff.min_fi : 16'd1};
      c1_in.sc_den = f_clamp ? ((c1_in.fp == 32'd0) ? 32'd1 : c1_in.fp) : 32'd1;
      c1_in.sc_rem = c1_in.sc_num;
      c1_in.sc_q = '0;
      if (f_clamp) c1_in.fp = {16'd0, cfg_ff.min_fi};
   end

   pmsp_pkg::cell_data_type bch [NSc+1];
   assign bch[0] = c1_ff;
   for (genvar g = 0; g < NSc; g++) begin : g_sb
      pmsp_scale_cell #(.BitIdx(NSc-1-g)) u_cell (
         .clock(clock), .reset(reset), .adv(adv), .d_in(bch[g]), .d_out(bch[g+1]));
   end

   always_comb begin
      c2_in = bch[NSc];
      c2_in.rp = c2_in.sc_q > {16'd0, pmsp_pkg::PERIOD_MAX} ? pmsp_pkg::PERIOD_MAX
               : c2_in.sc_q[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c0_ff.vld <= 1'b0; c1_ff.vld <= 1'b0; out_vld_ff <= 1'b0;
      end else if (adv) begin
         c0_ff.vld <= c0_in.vld; c1_ff.vld <= c1_in.vld; out_vld_ff <= c2_in.vld;
      end
      if (adv) begin
         c0_ff[$bits(c0_ff)-2:0] <= c0_in[$bits(c0_ff)-2:0];
         c1_ff[$bits(c1_ff)-2:0] <= c1_in[$bits(c1_ff)-2:0];
         out_data_ff <= {6'd0, c2_in.fp, c2_in.rp, !c2_in.fi_pos, c2_in.fi_ticks,
                         c2_in.r_dir, c2_in.r_ticks};
      end
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input blocked with empty output");
   a_zero_r: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[23:0] == 24'd0 |-> rsp_tdata[81:50] == 32'd0)
      else $error("radius period nonzero without ticks");
   a_zero_f: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[48:25] == 24'd0 |-> rsp_tdata[113:82] == 32'd0)
      else $error("angle period nonzero without ticks");
endmodule

// File: rtl/pmsp_div_cell.sv
// One restoring division step for both period dividers (n-th quotient bit from top).
module pmsp_div_cell #(
   parameter int unsigned BitIdx = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  pmsp_pkg::cell_data_type d_in,
   output pmsp_pkg::cell_data_type d_out
);
   pmsp_pkg::cell_data_type d_ff, d_in_c;
   logic [52:0] tr, tf;

   always_comb begin
      d_in_c = d_in;
      tr = {26'd0, d_in.rem_r} - ({28'd0, d_in.den_r} << BitIdx);
      tf = {26'd0, d_in.rem_fi} - ({28'd0, d_in.den_fi} << BitIdx);
      if (!tr[52]) begin
         d_in_c.rem_r = tr[26:0];
         d_in_c.rp[BitIdx] = 1'b1;
      end
      if (!tf[52]) begin
         d_in_c.rem_fi = tf[26:0];
         d_in_c.fp[BitIdx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) d_ff.vld <= 1'b0;
      else if (adv) d_ff.vld <= d_in.vld;
      if (adv) d_ff[$bits(d_ff)-2:0] <= d_in_c[$bits(d_ff)-2:0];
   end
   assign d_out = d_ff;
endmodule

// File: rtl/pmsp_scale_cell.sv
// One restoring step of other * minimum / period.
module pmsp_scale_cell #(
   parameter int unsigned BitIdx = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  pmsp_pkg::cell_data_type d_in,
   output pmsp_pkg::cell_data_type d_out
);
   pmsp_pkg::cell_data_type d_ff, d_in_c;
   logic [96:0] tq;

   always_comb begin
      d_in_c = d_in;
      tq = {49'd0, d_in.sc_rem} - ({65'd0, d_in.sc_den} << BitIdx);
      if (!tq[96]) begin
         d_in_c.sc_rem = tq[47:0];
         d_in_c.sc_q[BitIdx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) d_ff.vld <= 1'b0;
      else if (adv) d_ff.vld <= d_in.vld;
      if (adv) d_ff[$bits(d_ff)-2:0] <= d_in_c[$bits(d_ff)-2:0];
   end
   assign d_out = d_ff;
endmodule

// File: tb/sv/polar_move_step_planner_unit_test.sv
`timescale 1ns / 1ps

module polar_move_step_planner_unit_test;

   localparam int unsigned LATENCY = 130;
   localparam int unsigned IDLE_LIMIT = 20000;

   typedef struct packed {
      logic [23:0] r_ticks;
      logic        r_dir;
      logic [23:0] fi_ticks;
      logic        fi_dir;
      logic [31:0] r_period;
      logic [31:0] fi_period;
   } plan_type;

   typedef struct {
      logic [23:0] delta_r;
      logic [23:0] delta_fi;
      logic [25:0] move_time;
      bit          typed;
      plan_type    plan;
   } move_row_type;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [79:0]  req_tdata = '0;   // delta_r, delta_fi, move_time
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [119:0] rsp_tdata;        // r_ticks, r_dir, fi_ticks, fi_dir, r_period, fi_period
   logic         csr_psel = 0;
   logic         csr_penable = 0;
   logic         csr_pwrite = 0;
   logic [4:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   polar_move_step_planner_unit uut (.*);

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   logic [23:0] r_coef, fi_coef;
   logic [19:0] drift;
   logic [15:0] min_r, min_fi;

   plan_type expected_plans[$];
   int       errors = 0;
   int       idle_cycles = 0;
   bit       stall_mode = 0;

   function automatic plan_type plan_move(logic [23:0] dr, logic [23:0] df, logic [25:0] t);
      plan_type    p;
      logic [63:0] ar, af, rt, corr, rtk, ftk, rp, fp, d, v;
      logic [127:0] cp;
      bit          r_neg, fi_pos, add, positive;
      r_neg = dr[23];
      ar = r_neg ? 64'h100_0000 - 64'(dr) : 64'(dr);
      af = df[23] ? 64'h100_0000 - 64'(df) : 64'(df);
      fi_pos = !df[23] && af != 64'd0;
      rt = (ar * 64'(r_coef) + (64'd1 << 17)) >> 18;
      cp = (128'(af) * 128'(drift) * 128'(r_coef) + (128'd1 << 43)) >> 44;
      corr = cp[63:0];
      add = fi_pos ? !r_neg : r_neg;
      if (add) begin
         rtk = rt + corr;
         p.r_dir = !fi_pos;
      end else begin
         positive = rt > corr;
         rtk = positive ? rt - corr : corr - rt;
         p.r_dir = fi_pos ? positive : !positive;
      end
      if (rtk > 64'(pmsp_pkg::TICK_MAX)) rtk = 64'(pmsp_pkg::TICK_MAX);
      ftk = (af * 64'(fi_coef) + (64'd1 << 27)) >> 28;
      if (ftk > 64'(pmsp_pkg::TICK_MAX)) ftk = 64'(pmsp_pkg::TICK_MAX);
      rp = rtk == 64'd0 ? 64'd0 : (64'(t) + rtk) / (64'd2 * rtk);
      fp = ftk == 64'd0 ? 64'd0 : (64'(t) + ftk) / (64'd2 * ftk);
      if (rtk != 64'd0 && rp < 64'(min_r)) begin
         d = rp == 64'd0 ? 64'd1 : rp;
         v = fp * 64'(min_r) / d;
         fp = v > 64'(pmsp_pkg::PERIOD_MAX) ? 64'(pmsp_pkg::PERIOD_MAX) : v;
         rp = 64'(min_r);
      end
      if (ftk != 64'd0 && fp < 64'(min_fi)) begin
         d = fp == 64'd0 ? 64'd1 : fp;
         v = rp * 64'(min_fi) / d;
         rp = v > 64'(pmsp_pkg::PERIOD_MAX) ? 64'(pmsp_pkg::PERIOD_MAX) : v;
         fp = 64'(min_fi);
      end
      p.r_ticks = rtk[23:0];
      p.fi_ticks = ftk[23:0];
      p.fi_dir = !fi_pos;
      p.r_period = rp[31:0];
      p.fi_period = fp[31:0];
      return p;
   endfunction

   task automatic write_reg(logic [2:0] idx, logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1; csr_pwrite <= 1; csr_penable <= 0;
      csr_paddr <= {idx, 2'b00}; csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      case (idx)
         pmsp_pkg::REG_R_TICKS:  r_coef = value[23:0];
         pmsp_pkg::REG_FI_TICKS: fi_coef = value[23:0];
         pmsp_pkg::REG_R_DRIFT:  drift = value[19:0];
         pmsp_pkg::REG_MIN_R:    min_r = value[15:0];
         pmsp_pkg::REG_MIN_FI:   min_fi = value[15:0];
         default: ;
      endcase
   endtask

   task automatic set_config(logic [23:0] rc, logic [23:0] fc, logic [19:0] dr,
                             logic [15:0] mr, logic [15:0] mf);
      write_reg(pmsp_pkg::REG_R_TICKS, {8'd0, rc});
      write_reg(pmsp_pkg::REG_FI_TICKS, {8'd0, fc});
      write_reg(pmsp_pkg::REG_R_DRIFT, {12'd0, dr});
      write_reg(pmsp_pkg::REG_MIN_R, {16'd0, mr});
      write_reg(pmsp_pkg::REG_MIN_FI, {16'd0, mf});
   endtask

   task automatic drain;
      while (expected_plans.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   // One transfer; bursty gaps in front of it.
   task automatic send_move(logic [23:0] dr, logic [23:0] df, logic [25:0] t,
                            bit typed, plan_type plan);
      if ($urandom_range(0, 5) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {6'b0, t, df, dr};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_plans.push_back(typed ? plan : plan_move(dr, df, t));
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_plans.size() == 0) begin
               $display("%0t unexpected result %h", $time, rsp_tdata);
               errors++;
            end else begin
               plan_type want, got;
               want = expected_plans.pop_front();
               got.r_ticks = rsp_tdata[23:0];
               got.r_dir = rsp_tdata[24];
               got.fi_ticks = rsp_tdata[48:25];
               got.fi_dir = rsp_tdata[49];
               got.r_period = rsp_tdata[81:50];
               got.fi_period = rsp_tdata[113:82];
               if (got.r_ticks !== want.r_ticks || got.r_dir !== want.r_dir ||
                   got.fi_ticks !== want.fi_ticks || got.fi_dir !== want.fi_dir ||
                   got.r_period !== want.r_period || got.fi_period !== want.fi_period) begin
                  $display("%0t mismatch expected %h actual %h", $time, want, got);
                  errors++;
               end
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
         // Receiver: alternate between free-running and random stall stretches.
         if ($urandom_range(0, 63) == 0) stall_mode = !stall_mode;
         rsp_tready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
      end
   end

   move_row_type rows[$];
   plan_type     blank;

   function automatic void add_row(logic [23:0] dr, logic [23:0] df, logic [25:0] t,
                                   bit typed, plan_type p);
      move_row_type m;
      m.delta_r = dr; m.delta_fi = df; m.move_time = t; m.typed = typed; m.plan = p;
      rows.push_back(m);
   endfunction

   initial begin
      logic [23:0] dr, df;
      logic [25:0] t;
      blank = '0;
      r_coef = 24'd25600; fi_coef = 24'd163840; drift = 20'd65536;
      min_r = 16'd50; min_fi = 16'd50;
      repeat (12) @(posedge clock);
      reset <= 0;

      // zero move: no ticks, both periods zero, both direction bits set
      add_row(24'd0, 24'd0, 26'd0, 1, {24'd0, 1'b1, 24'd0, 1'b1, 32'd0, 32'd0});
      add_row(24'd0, 24'd0, 26'h3FF_FFFF, 1, {24'd0, 1'b1, 24'd0, 1'b1, 32'd0, 32'd0});
      add_row(24'h7FFFFF, 24'd0, 26'h3FF_FFFF, 0, blank);
      add_row(24'h800000, 24'd0, 26'd1000, 0, blank);
      add_row(24'd0, 24'h7FFFFF, 26'h3FF_FFFF, 0, blank);
      add_row(24'd0, 24'h800000, 26'd0, 0, blank);
      add_row(24'd1024, 24'd1048576, 26'd500000, 0, blank);
      add_row(24'hFFFC00, 24'd1048576, 26'd500000, 0, blank);
      add_row(24'd1024, 24'hF00000, 26'd500000, 0, blank);
      add_row(24'hFFFC00, 24'hF00000, 26'd500000, 0, blank);
      add_row(24'd409, 24'd1048576, 26'd12345, 0, blank);
      add_row(24'h7FFFFF, 24'h7FFFFF, 26'd3, 0, blank);
      add_row(24'd1, 24'd1, 26'd1, 0, blank);
      foreach (rows[i]) send_move(rows[i].delta_r, rows[i].delta_fi, rows[i].move_time,
                                  rows[i].typed, rows[i].plan);
      req_tvalid <= 0;
      drain();

      // saturating coefficients, minimums off
      set_config(24'hFFFFFF, 24'hFFFFFF, 20'hFFFFF, 16'd0, 16'd0);
      foreach (rows[i]) send_move(rows[i].delta_r, rows[i].delta_fi, rows[i].move_time,
                                  0, blank);
      req_tvalid <= 0;
      drain();

      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: set_config(24'd25600, 24'd163840, 20'd65536, 16'd50, 16'd50);
            1: set_config(24'd0, 24'd0, 20'd0, 16'hFFFF, 16'hFFFF);
            2: set_config(24'($urandom), 24'($urandom), 20'($urandom),
                          16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
            3: set_config(24'hFFFFFF, 24'($urandom_range(1000, 400000)), 20'hFFFFF, 16'd1,
                          16'hFFFF);
            default: set_config(24'($urandom_range(0, 60000)), 24'($urandom_range(0, 400000)),
                                20'($urandom_range(0, 200000)), 16'($urandom_range(0, 2000)),
                                16'($urandom_range(0, 2000)));
         endcase
         for (int n = 0; n < 100; n++) begin
            dr = 24'($urandom);
            df = 24'($urandom);
            case ($urandom_range(0, 3))
               0: t = 26'($urandom);
               1: t = 26'($urandom_range(0, 5000));
               2: begin
                  dr = 24'($urandom_range(0, 20000) - 10000);
                  df = 24'($urandom_range(0, 2000000) - 1000000);
                  t = 26'($urandom_range(0, 2000000));
               end
               default: t = 26'($urandom_range(0, 200));
            endcase
            send_move(dr, df, t, 0, blank);
         end
         req_tvalid <= 0;
         drain();
      end

      if (errors == 0 && expected_plans.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
